// ===== rtl/core/ms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_pkg
// Shared sizes, types and the store control bundle of the merge sorter.
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int unsigned Elements = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = $clog2(Elements);
  localparam int unsigned CntW     = $clog2(Elements + 1);

  typedef logic [DataW-1:0] data_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  // control of the two ping-pong stores, driven by the sequencer
  typedef struct packed {
    addr_t rd0_addr;
    addr_t rd1_addr;
    logic  a_we;
    addr_t a_waddr;
    logic  b_we;
    addr_t b_waddr;
    data_t wdata;
  } ram_ctrl_t;

  // one sorted item handed to the output register
  typedef struct packed {
    logic  push;
    data_t data;
    logic  last;
    logic  ovf;
  } emit_t;

endpackage

// ===== rtl/core/ms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// ===== rtl/core/ms_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_pick
// Shared compare unit: picks the next merge element from the two run heads.
// ----------------------------------------------------------------------------
module ms_pick (
  input  ms_pkg::data_t left_i,
  input  ms_pkg::data_t right_i,
  input  logic          left_ok_i,
  input  logic          right_ok_i,
  output logic          take_left_o,
  output ms_pkg::data_t pick_o
);
  import ms_pkg::*;

  logic left_less;

  // signed compare, a tie goes to the right run
  assign left_less   = $signed(left_i) < $signed(right_i);
  assign take_left_o = left_ok_i && (!right_ok_i || left_less);
  assign pick_o      = take_left_o ? left_i : right_i;

endmodule

// ===== rtl/core/ms_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_ctrl
// Sequencer: loads items, runs bottom-up merge passes between the two stores
// one element per cycle between setups, then streams the sorted set out.
// ----------------------------------------------------------------------------
module ms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  ms_pkg::data_t     in_value_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output ms_pkg::emit_t     emit_o,
  output ms_pkg::ram_ctrl_t ram_o,
  input  ms_pkg::data_t     a_rd0_i,
  input  ms_pkg::data_t     a_rd1_i,
  input  ms_pkg::data_t     b_rd0_i,
  input  ms_pkg::data_t     b_rd1_i
);
  import ms_pkg::*;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StMerge = 3'd2;
  localparam logic [2:0] StPrime = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  logic       ovf_q, ovf_d;
  cnt_t       width_q, width_d;
  cnt_t       lo_q, lo_d;
  cnt_t       mid_q, mid_d;
  cnt_t       hi_q, hi_d;
  cnt_t       i_q, i_d;
  cnt_t       j_q, j_d;
  cnt_t       k_q, k_d;
  cnt_t       e_q, e_d;
  logic       srcb_q, srcb_d;

  logic  accept;
  logic  left_ok, right_ok, take_left;
  data_t left_data, right_data, pick_data;
  cnt_t  cnt_inc, width2, mid_sum, hi_sum, mid_calc, hi_calc, lo_next;

  // run heads come from the store that is the source of this pass
  assign left_data  = srcb_q ? b_rd0_i : a_rd0_i;
  assign right_data = srcb_q ? b_rd1_i : a_rd1_i;
  assign left_ok    = i_q < mid_q;
  assign right_ok   = j_q < hi_q;

  ms_pick u_pick (
    .left_i     (left_data),
    .right_i    (right_data),
    .left_ok_i  (left_ok),
    .right_ok_i (right_ok),
    .take_left_o(take_left),
    .pick_o     (pick_data)
  );

  // merge bounds, clipped to the loaded count
  assign width2   = cnt_t'(width_q << 1);
  assign mid_sum  = lo_q + width_q;
  assign hi_sum   = lo_q + width2;
  assign mid_calc = (mid_sum > cnt_q) ? cnt_q : mid_sum;
  assign hi_calc  = (hi_sum > cnt_q) ? cnt_q : hi_sum;
  assign lo_next  = hi_sum;
  assign cnt_inc  = cnt_q + cnt_t'(1);

  assign in_ready_o = (state_q == StLoad);
  assign accept     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    e_d     = e_q;
    srcb_d  = srcb_q;
    ram_o.a_we    = 1'b0;
    ram_o.b_we    = 1'b0;
    ram_o.a_waddr = k_q[AddrW-1:0];
    ram_o.b_waddr = k_q[AddrW-1:0];
    ram_o.wdata   = pick_data;
    emit_o.push = 1'b0;
    emit_o.data = left_data;
    emit_o.last = 1'b0;
    emit_o.ovf  = 1'b0;

    unique case (state_q)
      StLoad: begin
        if (accept) begin
          if (cnt_q < cnt_t'(Elements)) begin
            ram_o.a_we    = 1'b1;
            ram_o.a_waddr = cnt_q[AddrW-1:0];
            ram_o.wdata   = in_value_i;
            cnt_d         = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            width_d = cnt_t'(1);
            lo_d    = '0;
            srcb_d  = 1'b0;
            e_d     = '0;
            state_d = (cnt_d > cnt_t'(1)) ? StSetup : StPrime;
          end
        end
      end
      StSetup: begin
        mid_d   = mid_calc;
        hi_d    = hi_calc;
        i_d     = lo_q;
        j_d     = mid_calc;
        k_d     = lo_q;
        state_d = StMerge;
      end
      StMerge: begin
        // write the picked head into the destination store
        if (srcb_q) begin
          ram_o.a_we = 1'b1;
        end else begin
          ram_o.b_we = 1'b1;
        end
        k_d = k_q + cnt_t'(1);
        if (take_left) begin
          i_d = i_q + cnt_t'(1);
        end else begin
          j_d = j_q + cnt_t'(1);
        end
        if (k_d == hi_q) begin
          if (lo_next >= cnt_q) begin
            // pass done: swap stores and double the run length
            srcb_d  = ~srcb_q;
            width_d = width2;
            lo_d    = '0;
            e_d     = '0;
            state_d = (width2 >= cnt_q) ? StPrime : StSetup;
          end else begin
            lo_d    = lo_next;
            state_d = StSetup;
          end
        end
      end
      StPrime: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free_i) begin
          emit_o.push = 1'b1;
          emit_o.last = (e_q + cnt_t'(1)) == cnt_q;
          emit_o.ovf  = emit_o.last && ovf_q;
          e_d         = e_q + cnt_t'(1);
          if (emit_o.last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase

    // read addresses lead the index registers so data lines up next cycle
    if (state_d == StPrime || state_d == StEmit) begin
      ram_o.rd0_addr = e_d[AddrW-1:0];
    end else begin
      ram_o.rd0_addr = i_d[AddrW-1:0];
    end
    ram_o.rd1_addr = j_d[AddrW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      e_q     <= '0;
      srcb_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      e_q     <= e_d;
      srcb_q  <= srcb_d;
    end
  end

endmodule

// ===== rtl/core/merge_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort
// Collects up to 64 signed values, sorts them by bottom-up merging between
// two ping-pong stores, and streams them out in ascending order.
// ----------------------------------------------------------------------------
//  channel  direction  item
//  s_axis   in         value in tdata, tlast ends the set
//  m_axis   out        sorted_value in tdata, end_of_run in tlast,
//                      overflow in tuser
//
// Items load into the element store as they are accepted. A set of n values
// then sorts in ceil(log2 n) passes through the single compare unit, with a
// setup step before each pair of runs. Emission starts with a prime state, then
// sends one item per cycle; a stalled m_axis holds the emission in place.
// s_axis_tready is low from the last item of a set until its final result
// enters the output register. Reset clears the control state only.
// ----------------------------------------------------------------------------
module merge_sort (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] value
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [31:0] sorted_value
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser    // [0] overflow
);
  import ms_pkg::*;

  ram_ctrl_t ram;
  emit_t     emit;
  data_t     a_rd0, a_rd1, b_rd0, b_rd1;
  logic      out_free;

  logic  m_valid_q;
  data_t m_data_q;
  logic  m_last_q;
  logic  m_user_q;

  assign out_free = !m_valid_q || m_axis_tready;

  ms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_value_i(s_axis_tdata),
    .in_ready_o(s_axis_tready),
    .out_free_i(out_free),
    .emit_o    (emit),
    .ram_o     (ram),
    .a_rd0_i   (a_rd0),
    .a_rd1_i   (a_rd1),
    .b_rd0_i   (b_rd0),
    .b_rd1_i   (b_rd1)
  );

  // element store, also the load target
  ms_ram #(
    .Width(DataW),
    .Depth(Elements)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (ram.a_we),
    .waddr_i (ram.a_waddr),
    .wdata_i (ram.wdata),
    .raddr0_i(ram.rd0_addr),
    .raddr1_i(ram.rd1_addr),
    .rdata0_o(a_rd0),
    .rdata1_o(a_rd1)
  );

  // scratch store
  ms_ram #(
    .Width(DataW),
    .Depth(Elements)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (ram.b_we),
    .waddr_i (ram.b_waddr),
    .wdata_i (ram.wdata),
    .raddr0_i(ram.rd0_addr),
    .raddr1_i(ram.rd1_addr),
    .rdata0_o(b_rd0),
    .rdata1_o(b_rd1)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit.push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit.push) begin
      m_data_q <= emit.data;
      m_last_q <= emit.last;
      m_user_q <= emit.ovf;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== test/ms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_checker
// Watches both streams of the merge sorter, rebuilds each loaded set, sorts
// it by bottom-up merging and compares every emitted item in order.
// ----------------------------------------------------------------------------
module ms_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_ready_i,
  input  ms_pkg::data_t s_data_i,
  input  logic          s_last_i,
  input  logic          m_valid_i,
  input  logic          m_ready_i,
  input  ms_pkg::data_t m_data_i,
  input  logic          m_last_i,
  input  logic          m_user_i,
  output int            mismatches_o,
  output int            pending_o
);
  import ms_pkg::*;

  // one predicted output item
  typedef struct packed {
    data_t value;
    logic  end_of_run;
    logic  overflow;
  } sorted_item_t;

  data_t        set_buf [Elements];
  data_t        merge_buf [Elements];
  int           set_len;
  logic         set_dropped;
  sorted_item_t sorted_q [$];

  // bottom-up merge, ties take the right run
  task automatic merge_sort_set(input int n);
    int w, lo, mid, hi, i, j, k;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w > n) ? n : lo + w;
        hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
        i = lo;
        j = mid;
        for (k = lo; k < hi; k++) begin
          if (i < mid && (j >= hi || $signed(set_buf[i]) < $signed(set_buf[j]))) begin
            merge_buf[k] = set_buf[i];
            i++;
          end else begin
            merge_buf[k] = set_buf[j];
            j++;
          end
        end
      end
      for (k = 0; k < n; k++) set_buf[k] = merge_buf[k];
    end
  endtask

  // store or drop one loaded value, emit predictions on the last one
  task automatic load_value(input data_t v, input logic fin);
    sorted_item_t it;
    int           k;
    if (set_len < Elements) begin
      set_buf[set_len] = v;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (fin) begin
      merge_sort_set(set_len);
      for (k = 0; k < set_len; k++) begin
        it.value      = set_buf[k];
        it.end_of_run = (k == set_len - 1);
        it.overflow   = (k == set_len - 1) ? set_dropped : 1'b0;
        sorted_q.push_back(it);
      end
      set_len     = 0;
      set_dropped = 1'b0;
    end
  endtask

  // compare one emitted item with the oldest prediction
  task automatic check_sorted(input data_t v, input logic eor, input logic ovf);
    sorted_item_t want;
    if (sorted_q.size() == 0) begin
      if (mismatches_o < 10)
        $display("unexpected sorted item %0d with nothing predicted", $signed(v));
      mismatches_o++;
    end else begin
      want = sorted_q.pop_front();
      if (want.value !== v || want.end_of_run !== eor || want.overflow !== ovf) begin
        if (mismatches_o < 10)
          $display("mismatch: value exp %0d got %0d, last exp %b got %b, ovf exp %b got %b",
                   $signed(want.value), $signed(v), want.end_of_run, eor,
                   want.overflow, ovf);
        mismatches_o++;
      end
    end
  endtask

  initial begin
    set_len      = 0;
    set_dropped  = 1'b0;
    mismatches_o = 0;
    pending_o    = 0;
  end

  // sample both channels at each accepting edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid_i && m_ready_i) check_sorted(m_data_i, m_last_i, m_user_i);
      if (s_valid_i && s_ready_i) load_value(s_data_i, s_last_i);
      pending_o = sorted_q.size();
    end
  end

endmodule

// ===== test/tb_merge_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_merge_sort
// Feeds sets of signed values to the merge sorter with bursty input and a
// stalling output, including full and overflowing sets, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb_merge_sort;
  import ms_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int HoldOff   = 400;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;
  typedef enum int {VAL_ANY, VAL_NARROW, VAL_EDGE} val_mode_e;

  logic  clk_i;
  logic  rst_ni;
  logic  s_tvalid;
  logic  s_tready;
  data_t s_tdata;
  logic  s_tlast;
  logic  m_tvalid;
  logic  m_tready;
  data_t m_tdata;
  logic  m_tlast;
  logic  m_tuser;

  int    mismatches;
  int    pending;
  int    idle_cycles;
  int    results_seen;
  int    items_sent;
  int    burst_left;

  merge_sort dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  ms_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .s_last_i     (s_tlast),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .m_last_i     (m_tlast),
    .m_user_i     (m_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // activity counters for the watchdog and the hold-off trigger
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && m_tvalid && m_tready) results_seen <= results_seen + 1;
  end

  // watchdog on cycles without any accepted item
  initial begin
    idle_cycles  = 0;
    results_seen = 0;
    @(posedge clk_i);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // output side: one long hold-off, otherwise segments of varying stall
  initial begin
    bit       held;
    int       seg;
    rx_mode_e mode;
    held = 1'b0;
    m_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(16, 128);
      repeat (seg) begin
        case (mode)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_HALF:   m_tready <= $urandom_range(0, 1);
          RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic data_t pick_value(input val_mode_e mode);
    case (mode)
      VAL_NARROW: return data_t'($urandom_range(0, 8) - 4);
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return $urandom;
    endcase
  endfunction

  // offer one item, then maybe open a gap between bursts
  task automatic push_value(input data_t v, input logic fin);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic push_set(input data_t vals[$]);
    int k;
    for (k = 0; k < vals.size(); k++) push_value(vals[k], k == vals.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    int        size, k, pick;
    val_mode_e vmode;
    items_sent = 0;
    burst_left = 4;
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single extremes, mixed extremes, ties, ordered and reversed
    push_set('{32'h7FFF_FFFF});
    push_set('{32'h8000_0000});
    push_set('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1});
    push_set('{32'd7, -32'sd3, 32'd7, 32'd7, -32'sd3, 32'd0});
    push_set('{32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
    push_set('{-32'sd2, 32'd0, 32'd9});

    // random sets, mostly small, some full and some overflowing
    while (items_sent < 500) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) size = Elements;
      else if (pick == 1) size = $urandom_range(Elements + 1, Elements + 8);
      else size = $urandom_range(1, 16);
      vmode = val_mode_e'($urandom_range(0, 2));
      for (k = 0; k < size; k++) push_value(pick_value(vmode), k == size - 1);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // drain, then allow time for stray items
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== merge_sort.f =====
rtl/core/ms_pkg.sv
rtl/core/ms_ram.sv
rtl/core/ms_pick.sv
rtl/core/ms_ctrl.sv
rtl/core/merge_sort.sv
test/ms_checker.sv
test/tb_merge_sort.sv
